// ===== hdl/fchf_pkg.sv =====
// Shared types, register indexes and reset constants for the framed command history filter.
package fchf_pkg;

    // Frame bytes and frame layout
    localparam int WindowLen      = 4;
    localparam int ByteW          = 8;
    localparam int LimitW         = 11;
    localparam int HistoryDepthDef = 5;

    // Reset values
    localparam logic [ByteW-1:0]  StartMarkerRst = 8'd5;
    localparam logic [ByteW-1:0]  EndMarkerRst   = 8'd6;
    localparam logic [LimitW-1:0] SignLowRst     = 11'd100;
    localparam logic [LimitW-1:0] SignHighRst    = 11'd400;
    localparam logic [ByteW-1:0]  SteerRst       = 8'd100;
    localparam logic [ByteW-1:0]  CollRst        = 8'd0;
    localparam logic [ByteW-1:0]  SignRst        = 8'd50;
    localparam logic [8:0]        SteerOffset    = 9'd100;

    // Sign class codes (2-bit two's complement)
    localparam logic [1:0] ClassMinus = 2'b11;
    localparam logic [1:0] ClassZero  = 2'b00;
    localparam logic [1:0] ClassPlus  = 2'b01;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_END_MARKER   = 2'd1,
        CFG_SIGN_LOW     = 2'd2,
        CFG_SIGN_HIGH    = 2'd3
    } t_cfg_idx;

    // Frame hit and its payload bytes
    typedef struct packed {
        logic             hit;
        logic [ByteW-1:0] steer;
        logic [ByteW-1:0] coll;
        logic [ByteW-1:0] sign;
    } t_frame;

    // One result item
    typedef struct packed {
        logic [1:0]       sign_class;
        logic [ByteW-1:0] coll_avg_centi;
        logic [8:0]       steer_avg_centi;
    } t_result;

endpackage

// ===== hdl/fchf_frame_detect.sv =====
// Four-byte match window and frame detection.
module fchf_frame_detect
    import fchf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [ByteW-1:0] i_byte,
    input  logic [ByteW-1:0] i_start_marker,
    input  logic [ByteW-1:0] i_end_marker,
    output t_frame           o_frame
);

    logic [ByteW-1:0] r_win [WindowLen];

    // Detect a frame on the oldest byte and the incoming byte
    always_comb begin
        o_frame.hit   = (r_win[0] == i_start_marker) && (i_byte == i_end_marker);
        o_frame.steer = r_win[1];
        o_frame.coll  = r_win[2];
        o_frame.sign  = r_win[3];
    end

    // Shift the byte in, or clear the window once a frame is found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WindowLen; k++) r_win[k] <= '0;
        end else if (i_advance) begin
            if (o_frame.hit) begin
                for (int k = 0; k < WindowLen; k++) r_win[k] <= '0;
            end else begin
                for (int k = 0; k < WindowLen - 1; k++) r_win[k] <= r_win[k+1];
                r_win[WindowLen-1] <= i_byte;
            end
        end
    end

    // A found frame leaves an empty window
    a_clear_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_frame.hit |=> r_win[0] == '0 && r_win[3] == '0)
        else $error("window not cleared after frame");

endmodule

// ===== hdl/fchf_history.sv =====
// History rings with running sums, averages by reciprocal multiply and sign class.
module fchf_history
    import fchf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HistoryDepthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_write,
    input  t_frame            i_frame,
    input  logic [LimitW-1:0] i_sign_low,
    input  logic [LimitW-1:0] i_sign_high,
    output t_result           o_result
);

    localparam int PtrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SumW  = $clog2(255 * HISTORY_DEPTH + 1);
    localparam int Shift = SumW + 5;
    localparam int RecipW = Shift + 1;
    localparam longint Recip = ((64'd1 << Shift) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int ProdW = SumW + RecipW;
    localparam int CmpW  = (SumW > LimitW) ? SumW : LimitW;
    localparam logic [RecipW-1:0] RecipC = RecipW'(Recip);
    localparam logic [SumW-1:0] SteerSumRst = SumW'(HISTORY_DEPTH * 100);
    localparam logic [SumW-1:0] SignSumRst  = SumW'(HISTORY_DEPTH * 50);

    logic [ByteW-1:0] r_steer [HISTORY_DEPTH];
    logic [ByteW-1:0] r_coll  [HISTORY_DEPTH];
    logic [ByteW-1:0] r_sign  [HISTORY_DEPTH];
    logic [PtrW-1:0]  r_ptr, n_ptr;
    logic [SumW-1:0]  r_steer_sum, n_steer_sum;
    logic [SumW-1:0]  r_coll_sum, n_coll_sum;
    logic [SumW-1:0]  r_sign_sum, n_sign_sum;
    logic [ProdW-1:0] steer_prod, coll_prod;
    logic [ByteW-1:0] steer_avg, coll_avg;
    logic [CmpW-1:0]  sign_cmp;

    // Swap the oldest entry for the new byte in each running sum
    always_comb begin
        n_steer_sum = r_steer_sum - SumW'(r_steer[r_ptr]) + SumW'(i_frame.steer);
        n_coll_sum  = r_coll_sum  - SumW'(r_coll[r_ptr])  + SumW'(i_frame.coll);
        n_sign_sum  = r_sign_sum  - SumW'(r_sign[r_ptr])  + SumW'(i_frame.sign);
        n_ptr       = (r_ptr == PtrW'(HISTORY_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    end

    // Floor divide by the depth through a reciprocal multiply
    always_comb begin
        steer_prod = ProdW'(n_steer_sum) * ProdW'(RecipC);
        coll_prod  = ProdW'(n_coll_sum) * ProdW'(RecipC);
        steer_avg  = steer_prod[Shift +: ByteW];
        coll_avg   = coll_prod[Shift +: ByteW];
        sign_cmp   = CmpW'(n_sign_sum);
    end

    // Form the result; low test goes first
    always_comb begin
        o_result.steer_avg_centi = {1'b0, steer_avg} - SteerOffset;
        o_result.coll_avg_centi  = coll_avg;
        if (sign_cmp < CmpW'(i_sign_low)) begin
            o_result.sign_class = ClassMinus;
        end else if (sign_cmp <= CmpW'(i_sign_high)) begin
            o_result.sign_class = ClassZero;
        end else begin
            o_result.sign_class = ClassPlus;
        end
    end

    // Write the rings and sums on each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_steer[k] <= SteerRst;
                r_coll[k]  <= CollRst;
                r_sign[k]  <= SignRst;
            end
            r_ptr       <= '0;
            r_steer_sum <= SteerSumRst;
            r_coll_sum  <= '0;
            r_sign_sum  <= SignSumRst;
        end else if (i_write) begin
            r_steer[r_ptr] <= i_frame.steer;
            r_coll[r_ptr]  <= i_frame.coll;
            r_sign[r_ptr]  <= i_frame.sign;
            r_ptr          <= n_ptr;
            r_steer_sum    <= n_steer_sum;
            r_coll_sum     <= n_coll_sum;
            r_sign_sum     <= n_sign_sum;
        end
    end

    // Pointer stays inside the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PtrW'(HISTORY_DEPTH - 1))
        else $error("history pointer out of range");

    // Pointer moves only on a frame write
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_write |=> $stable(r_ptr))
        else $error("history pointer moved without a frame");

endmodule

// ===== hdl/framed_command_history_filter.sv =====
// Top level: input register, frame detect, history update and result register.
// One received byte is taken per cycle unless a frame byte is held back: each item passes through the
// input register, where frame detection, the history update and both averages are done,
// and a frame's result then sits in the output register until taken. Bytes that complete
// no frame never wait on the output side; a frame byte waits only while a previous result
// is still held. There is no clearing pass: all history state comes out of reset valid.
// Output tdata holds steer_avg_centi [8:0] (signed), coll_avg_centi [16:9] and
// sign_class [18:17] (signed); the configuration port takes register index 0 start marker,
// 1 end marker, 2 sign low limit, 3 sign high limit.
module framed_command_history_filter
    import fchf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HistoryDepthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    // Result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [8:0] steer_avg_centi, [16:9] coll_avg_centi,
                                              // [18:17] sign_class, [23:19] zero
    // Configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [LimitW-1:0] i_cfg_wdata
);

    logic [ByteW-1:0]  r_start_marker, r_end_marker;
    logic [LimitW-1:0] r_sign_low, r_sign_high;
    logic              r_in_valid;
    logic [ByteW-1:0]  r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_frame            frame;
    t_result           result;
    logic              out_free;
    logic              fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= StartMarkerRst;
            r_end_marker   <= EndMarkerRst;
            r_sign_low     <= SignLowRst;
            r_sign_high    <= SignHighRst;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata[ByteW-1:0];
                CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata[ByteW-1:0];
                CFG_SIGN_LOW:     r_sign_low     <= i_cfg_wdata;
                CFG_SIGN_HIGH:    r_sign_high    <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Advance the held item unless its result would overrun a waiting one
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && (!frame.hit || out_free);
    assign s_axis_tready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    fchf_frame_detect u_detect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (fire),
        .i_byte         (r_in_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_frame        (frame)
    );

    fchf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_write     (fire && frame.hit),
        .i_frame     (frame),
        .i_sign_low  (r_sign_low),
        .i_sign_high (r_sign_high),
        .o_result    (result)
    );

    // Result register: load on a frame, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && frame.hit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && frame.hit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.sign_class, r_out.coll_avg_centi, r_out.steer_avg_centi};

    // A new result only follows a frame item leaving the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && frame.hit))
        else $error("result without a frame");

    // A frame item never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && fire |-> !frame.hit)
        else $error("pending result overwritten");

    // Sign class is never the unused code
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.sign_class != 2'b10)
        else $error("bad sign class");

endmodule
